// ----- hdl/pgs_pkg.sv -----
// ----------------------------------------------------------------------------
// Point grid snap package
// Shared types, sizes and operation codes of the point grid snap block.
// ----------------------------------------------------------------------------
package pgs_pkg;

  localparam int MAX_POINTS = 1024;
  localparam int PT_AW      = $clog2(MAX_POINTS);
  localparam int PT_CW      = PT_AW + 1;

  // Snap divider: numerator 2*|c| + step fits in 33 bits; 34 are used.
  localparam int SNAP_NUM_W = 34;
  localparam int SNAP_CNT_W = $clog2(SNAP_NUM_W + 1);

  localparam logic [1:0] MODE_LOAD   = 2'd0;
  localparam logic [1:0] MODE_FINISH = 2'd1;
  localparam logic [1:0] MODE_READ   = 2'd2;
  localparam logic [1:0] MODE_CLEAR  = 2'd3;

  localparam logic CFG_GRID_STEP   = 1'b0;
  localparam logic CFG_CARRY_COLOR = 1'b1;

  typedef struct packed {
    logic [1:0]         mode;
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
    logic signed [31:0] coord_z;
    logic [23:0]        color_in;
    logic               invalid_in;
  } in_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic [23:0]        color_out;
    logic               point_valid;
    logic               last_point;
    logic [10:0]        unique_count;
    logic               overflowed;
  } out_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic [23:0]        color;
  } pt_t;

  localparam int PT_W = $bits(pt_t);

  // True when point a sorts strictly ahead of point b in descending order.
  function automatic logic ranks_before(pt_t a, pt_t b);
    logic r;
    if (a.x != b.x) begin
      r = a.x > b.x;
    end else if (a.y != b.y) begin
      r = a.y > b.y;
    end else begin
      r = a.z > b.z;
    end
    return r;
  endfunction

endpackage

// ----- hdl/pgs_ram.sv -----
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module pgs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hdl/pgs_snap.sv -----
// ----------------------------------------------------------------------------
// Grid snap unit
// Rounds one coordinate to the nearest grid multiple with a bit-serial
// restoring divider, then saturates to the signed 32-bit range.
// ----------------------------------------------------------------------------
module pgs_snap import pgs_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [31:0] coord,
  input  logic [30:0]        step,
  output logic               done,
  output logic signed [31:0] result
);

  logic                  busy;
  logic                  fin;
  logic                  neg;
  logic [SNAP_CNT_W-1:0] cnt;
  logic [SNAP_NUM_W-1:0] num_sh;
  logic [SNAP_NUM_W-1:0] num_keep;
  logic [31:0]           den;
  logic [31:0]           rem;

  logic [30:0]           step_eff;
  logic [32:0]           mag;
  logic [SNAP_NUM_W-1:0] num_start;
  logic [32:0]           trial;
  logic [SNAP_NUM_W-1:0] diff;
  logic [32:0]           half;

  always_comb begin
    step_eff  = (step == '0) ? 31'd1 : step;
    mag       = coord[31] ? (33'd0 - {coord[31], coord}) : {coord[31], coord};
    num_start = {mag, 1'b0} + {3'b000, step_eff};
    trial     = {rem, num_sh[SNAP_NUM_W-1]};
    diff      = num_keep - {2'b00, rem};
    half      = diff[SNAP_NUM_W-1:1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      fin  <= 1'b0;
      if (start) begin
        busy     <= 1'b1;
        cnt      <= SNAP_CNT_W'(SNAP_NUM_W);
        num_sh   <= num_start;
        num_keep <= num_start;
        den      <= {step_eff, 1'b0};
        rem      <= '0;
        neg      <= coord[31];
      end else if (busy) begin
        if (trial >= {1'b0, den}) begin
          rem <= 32'(trial - {1'b0, den});
        end else begin
          rem <= trial[31:0];
        end
        num_sh <= {num_sh[SNAP_NUM_W-2:0], 1'b0};
        cnt    <= cnt - 1'b1;
        if (cnt == SNAP_CNT_W'(1)) begin
          busy <= 1'b0;
          fin  <= 1'b1;
        end
      end else if (fin) begin
        // The quotient times the step equals half of (numerator - remainder).
        done <= 1'b1;
        if (!neg && half > 33'h0_7FFF_FFFF) begin
          result <= 32'sh7FFF_FFFF;
        end else if (neg && half > 33'h0_8000_0000) begin
          result <= 32'sh8000_0000;
        end else if (neg) begin
          result <= 32'(33'd0 - half);
        end else begin
          result <= half[31:0];
        end
      end
    end
  end

endmodule

// ----- hdl/point_grid_snap_sort_dedup.sv -----
// ----------------------------------------------------------------------------
// Point grid snap, sort and deduplicate
// A load snaps x, y and z in turn with one shared divider; a clear acts on
// accept; an empty read answers straight from idle, any other via ST_READ.
// Finish runs an insertion sort over the point RAM (key fetch, key load and
// compare states per key, n*n/2 compares worst case) and a dedup pass that
// reads and then compares each point.
// One request is worked at a time. Reset is synchronous; the point RAM is
// not cleared, only entries below the loaded count are ever read.
// ----------------------------------------------------------------------------
module point_grid_snap_sort_dedup import pgs_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [30:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_t         in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_t        out_data
);

  // One-hot sequencer states.
  typedef enum logic [8:0] {
    ST_IDLE      = 9'b000000001,
    ST_SNAP      = 9'b000000010,
    ST_SORT_KEY  = 9'b000000100,
    ST_SORT_LOAD = 9'b000001000,
    ST_SORT_CMP  = 9'b000010000,
    ST_SORT_PUT  = 9'b000100000,
    ST_DD_RD     = 9'b001000000,
    ST_DD_CMP    = 9'b010000000,
    ST_READ      = 9'b100000000
  } state_t;

  state_t state;

  // Configuration registers.
  logic [30:0] grid_step;
  logic        carry_color;

  // Store bookkeeping.
  logic [PT_CW-1:0] loaded_count;
  logic [PT_CW-1:0] kept_count;
  logic [PT_CW-1:0] read_pointer;
  logic             overflow_flag;
  logic             emitting;

  // Load path: captured request and snapped results.
  logic [1:0]         ci;
  logic signed [31:0] cy;
  logic signed [31:0] cz;
  logic [23:0]        ccolor;
  logic signed [31:0] rx;
  logic signed [31:0] ry;

  // Sort and dedup indices.
  logic [PT_CW-1:0] si;
  logic [PT_CW-1:0] j;
  logic [PT_CW-1:0] di;
  logic [PT_CW-1:0] w;
  pt_t              key;
  pt_t              last;

  logic accept;
  logic empty_read;
  logic snap_start;
  logic snap_done;
  logic signed [31:0] snap_coord;
  logic signed [31:0] snap_result;

  logic             ram_we;
  logic [PT_AW-1:0] ram_waddr;
  pt_t              ram_wdata;
  logic [PT_AW-1:0] ram_raddr;
  pt_t              ram_rdata;

  logic [PT_CW-1:0] si_m1;
  logic [PT_CW-1:0] j_m2;
  logic             key_first;
  logic             dup;

  // A new request is taken only when the sequencer is idle and no finished
  // result is stuck at the output.
  assign in_stall = (state != ST_IDLE) || (out_valid && out_stall);
  assign accept   = in_valid && !in_stall;

  // A read with nothing to deliver answers in the accepting cycle, so the
  // output register is loaded again in the same cycle it may be drained.
  assign empty_read = accept && (in_data.mode == MODE_READ) &&
                      !(emitting && read_pointer < kept_count);

  assign si_m1     = si - 1'b1;
  assign j_m2      = j - PT_CW'(2);
  assign key_first = ranks_before(key, ram_rdata);
  assign dup       = (w != '0) && (ram_rdata.x == last.x) && (ram_rdata.y == last.y) &&
                     (ram_rdata.z == last.z);

  // The snap unit is started on x at accept, then on y and z as each finishes.
  always_comb begin
    snap_start = 1'b0;
    snap_coord = in_data.coord_x;
    if (state == ST_IDLE) begin
      snap_start = accept && (in_data.mode == MODE_LOAD) && !emitting &&
                   !in_data.invalid_in && (loaded_count < PT_CW'(MAX_POINTS));
    end else if (state == ST_SNAP && snap_done && ci != 2'd2) begin
      snap_start = 1'b1;
      snap_coord = (ci == 2'd0) ? cy : cz;
    end
  end

  // RAM read address: each state presents the entry the next state consumes.
  always_comb begin
    unique case (state)
      ST_IDLE:      ram_raddr = read_pointer[PT_AW-1:0];
      ST_SORT_KEY:  ram_raddr = si[PT_AW-1:0];
      ST_SORT_LOAD: ram_raddr = si_m1[PT_AW-1:0];
      ST_SORT_CMP:  ram_raddr = j_m2[PT_AW-1:0];
      ST_DD_RD:     ram_raddr = di[PT_AW-1:0];
      default:      ram_raddr = read_pointer[PT_AW-1:0];
    endcase
  end

  // RAM write port: load results, sort shifts and key drops, dedup compaction.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = j[PT_AW-1:0];
    ram_wdata = key;
    unique case (state)
      ST_SNAP: begin
        ram_we    = snap_done && (ci == 2'd2);
        ram_waddr = loaded_count[PT_AW-1:0];
        ram_wdata = '{x: rx, y: ry, z: snap_result, color: ccolor};
      end
      ST_SORT_CMP: begin
        ram_we    = 1'b1;
        ram_wdata = key_first ? ram_rdata : key;
      end
      ST_SORT_PUT: begin
        ram_we = 1'b1;
      end
      ST_DD_CMP: begin
        ram_we    = !dup;
        ram_waddr = w[PT_AW-1:0];
        ram_wdata = ram_rdata;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      grid_step     <= 31'd65536;
      carry_color   <= 1'b0;
      loaded_count  <= '0;
      kept_count    <= '0;
      read_pointer  <= '0;
      overflow_flag <= 1'b0;
      emitting      <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_GRID_STEP:   grid_step   <= cfg_data;
          CFG_CARRY_COLOR: carry_color <= cfg_data[0];
          default:         grid_step   <= grid_step;
        endcase
      end

      if (out_valid && !out_stall && !empty_read) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            unique case (in_data.mode)
              MODE_LOAD: begin
                ci     <= 2'd0;
                cy     <= in_data.coord_y;
                cz     <= in_data.coord_z;
                ccolor <= in_data.color_in;
                if (!emitting && !in_data.invalid_in) begin
                  if (loaded_count < PT_CW'(MAX_POINTS)) begin
                    state <= ST_SNAP;
                  end else begin
                    overflow_flag <= 1'b1;
                  end
                end
              end
              MODE_FINISH: begin
                si    <= PT_CW'(1);
                state <= ST_SORT_KEY;
              end
              MODE_READ: begin
                if (!empty_read) begin
                  state <= ST_READ;
                end else begin
                  // Nothing left to deliver: an empty result with status only.
                  out_valid <= 1'b1;
                  out_data  <= '{out_x: '0, out_y: '0, out_z: '0, color_out: '0,
                                 point_valid: 1'b0, last_point: 1'b0,
                                 unique_count: kept_count,
                                 overflowed: overflow_flag};
                end
              end
              MODE_CLEAR: begin
                loaded_count  <= '0;
                kept_count    <= '0;
                read_pointer  <= '0;
                overflow_flag <= 1'b0;
                emitting      <= 1'b0;
              end
              default: state <= ST_IDLE;
            endcase
          end
        end

        ST_SNAP: begin
          if (snap_done) begin
            ci <= ci + 1'b1;
            if (ci == 2'd0) begin
              rx <= snap_result;
            end else if (ci == 2'd1) begin
              ry <= snap_result;
            end else begin
              // The z result goes straight into the RAM this cycle.
              loaded_count <= loaded_count + 1'b1;
              state        <= ST_IDLE;
            end
          end
        end

        // Insertion sort: take entry si as the key and walk it downward.
        ST_SORT_KEY: begin
          if (si >= loaded_count) begin
            di    <= '0;
            w     <= '0;
            state <= ST_DD_RD;
          end else begin
            state <= ST_SORT_LOAD;
          end
        end

        ST_SORT_LOAD: begin
          key   <= ram_rdata;
          j     <= si;
          state <= ST_SORT_CMP;
        end

        ST_SORT_CMP: begin
          if (key_first) begin
            // The neighbor moves up one place; the key keeps walking.
            j <= j - 1'b1;
            if (j == PT_CW'(1)) begin
              state <= ST_SORT_PUT;
            end
          end else begin
            si    <= si + 1'b1;
            state <= ST_SORT_KEY;
          end
        end

        ST_SORT_PUT: begin
          si    <= si + 1'b1;
          state <= ST_SORT_KEY;
        end

        // Dedup: compact the sorted run, dropping exact coordinate repeats.
        ST_DD_RD: begin
          if (di == loaded_count) begin
            kept_count   <= w;
            loaded_count <= w;
            read_pointer <= '0;
            emitting     <= 1'b1;
            out_valid    <= 1'b1;
            out_data     <= '{out_x: '0, out_y: '0, out_z: '0, color_out: '0,
                              point_valid: 1'b0, last_point: 1'b0,
                              unique_count: w, overflowed: overflow_flag};
            state        <= ST_IDLE;
          end else begin
            state <= ST_DD_CMP;
          end
        end

        ST_DD_CMP: begin
          if (!dup) begin
            last <= ram_rdata;
            w    <= w + 1'b1;
          end
          di    <= di + 1'b1;
          state <= ST_DD_RD;
        end

        ST_READ: begin
          out_valid    <= 1'b1;
          out_data     <= '{out_x: ram_rdata.x, out_y: ram_rdata.y, out_z: ram_rdata.z,
                            color_out: carry_color ? ram_rdata.color : 24'd0,
                            point_valid: 1'b1,
                            last_point: (read_pointer + 1'b1) == kept_count,
                            unique_count: kept_count, overflowed: overflow_flag};
          read_pointer <= read_pointer + 1'b1;
          state        <= ST_IDLE;
        end

        default: state <= ST_IDLE;
      endcase
    end
  end

  pgs_snap u_snap (
    .clk    (clk),
    .rst    (rst),
    .start  (snap_start),
    .coord  (snap_coord),
    .step   (grid_step),
    .done   (snap_done),
    .result (snap_result)
  );

  pgs_ram #(
    .WIDTH (PT_W),
    .DEPTH (MAX_POINTS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  a_loaded_bound: assert property (@(posedge clk) disable iff (rst)
    loaded_count <= PT_CW'(MAX_POINTS))
    else $error("loaded count exceeds capacity");

  a_sort_index: assert property (@(posedge clk) disable iff (rst)
    state == ST_SORT_CMP |-> (j != '0) && (j < loaded_count))
    else $error("sort index out of range");

  a_dedup_order: assert property (@(posedge clk) disable iff (rst)
    state == ST_DD_CMP |-> w <= di)
    else $error("dedup write index passed read index");

  a_emit_exit: assert property (@(posedge clk) disable iff (rst)
    $fell(emitting) |-> $past(accept && in_data.mode == MODE_CLEAR))
    else $error("emitting phase left without a clear");

endmodule

// ----- test/point_grid_snap_sort_dedup_tb.sv -----
// ----------------------------------------------------------------------------
// Point grid snap, sort and deduplicate testbench
// Feeds loads, finishes, reads and clears through the request channel,
// predicts every result with a behavioral copy of the block, and compares
// each delivered result field by field. Idle gaps on both sides, a long
// receiver hold-off and a full-store overflow run are included.
// ----------------------------------------------------------------------------
module point_grid_snap_sort_dedup_tb import pgs_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 4000000;
  localparam int SETTLE      = 200;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic        cfg_index = CFG_GRID_STEP;
  logic [30:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_t         in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_t        out_data;

  always #2 clk = ~clk;

  point_grid_snap_sort_dedup DUT (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  // Requests waiting to be driven and results waiting to be seen.
  in_t  request_q[$];
  out_t result_q[$];
  int   mismatches = 0;

  // Behavioral copy of the block: point store, counters and registers.
  pt_t         cloud[MAX_POINTS];
  int          n_loaded, n_kept, rd_ptr;
  bit          ovf, emitting;
  logic [30:0] step_reg;
  bit          color_on;

  function automatic logic signed [31:0] snap_coord(logic signed [31:0] c);
    longint s, a, q, r;
    s = longint'(step_reg);
    if (s == 0) s = 1;
    a = (c < 0) ? -longint'(c) : longint'(c);
    q = (2 * a + s) / (2 * s);
    r = q * s;
    if (c < 0) r = -r;
    if (r > 64'sd2147483647) r = 64'sd2147483647;
    if (r < -64'sd2147483648) r = -64'sd2147483648;
    return r[31:0];
  endfunction

  function automatic bit sorts_ahead(pt_t a, pt_t b);
    if (a.x != b.x) return a.x > b.x;
    if (a.y != b.y) return a.y > b.y;
    return a.z > b.z;
  endfunction

  // Stable insertion sort, then drop exact coordinate repeats keeping the first.
  function automatic void sort_and_merge();
    pt_t key;
    int  j, w;
    for (int i = 1; i < n_loaded; i++) begin
      key = cloud[i];
      j = i;
      while (j > 0 && sorts_ahead(key, cloud[j-1])) begin
        cloud[j] = cloud[j-1];
        j--;
      end
      cloud[j] = key;
    end
    w = 0;
    for (int i = 0; i < n_loaded; i++) begin
      if (w > 0 && cloud[i].x == cloud[w-1].x && cloud[i].y == cloud[w-1].y &&
          cloud[i].z == cloud[w-1].z) continue;
      cloud[w] = cloud[i];
      w++;
    end
    n_kept = w;
    n_loaded = w;
  endfunction

  // Applies one accepted request and queues the result it causes, if any.
  function automatic void apply_request(in_t r);
    out_t o;
    o = '0;
    case (r.mode)
      MODE_LOAD: begin
        if (!emitting && !r.invalid_in) begin
          if (n_loaded >= MAX_POINTS) begin
            ovf = 1'b1;
          end else begin
            cloud[n_loaded] = '{snap_coord(r.coord_x), snap_coord(r.coord_y),
                                snap_coord(r.coord_z), r.color_in};
            n_loaded++;
          end
        end
        return;
      end
      MODE_CLEAR: begin
        n_loaded = 0; n_kept = 0; rd_ptr = 0; ovf = 0; emitting = 0;
        return;
      end
      MODE_FINISH: begin
        sort_and_merge();
        rd_ptr = 0;
        emitting = 1'b1;
      end
      default: begin
        if (emitting && rd_ptr < n_kept) begin
          o.out_x = cloud[rd_ptr].x;
          o.out_y = cloud[rd_ptr].y;
          o.out_z = cloud[rd_ptr].z;
          o.color_out = color_on ? cloud[rd_ptr].color : 24'd0;
          o.point_valid = 1'b1;
          o.last_point = (rd_ptr + 1 == n_kept);
          rd_ptr++;
        end
      end
    endcase
    o.unique_count = n_kept[10:0];
    o.overflowed = ovf;
    result_q.push_back(o);
  endfunction

  // Driver: bursts of random length separated by random gaps.
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) apply_request(in_data);
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (request_q.size() > 0) begin
          in_data <= request_q.pop_front();
          in_valid <= 1'b1;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 40);
          end
          burst_left--;
          if (burst_left == 0) begin
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver stall pattern. The pattern changes every so often between no
  // stalls, light stalls and heavy stalls. A hold-off request from the
  // stimulus forces a long unbroken stall so that the block backs up.
  int hold_asked = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int stall_style = 0;
  int style_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_seen != hold_asked) begin
      hold_seen = hold_asked;
      hold_left = 600;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      if (style_left <= 0) begin
        stall_style = $urandom_range(0, 2);
        style_left = $urandom_range(20, 300);
      end
      style_left--;
      case (stall_style)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 9) < 3);
        default: out_stall <= ($urandom_range(0, 9) < 7);
      endcase
    end
  end

  // Monitor: every accepted result must match the oldest expectation.
  always @(posedge clk) begin
    out_t want;
    if (!rst && out_valid && !out_stall) begin
      if (result_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: unexpected result %h", out_data);
      end else begin
        want = result_q.pop_front();
        if (out_data.out_x !== want.out_x || out_data.out_y !== want.out_y ||
            out_data.out_z !== want.out_z || out_data.color_out !== want.color_out ||
            out_data.point_valid !== want.point_valid ||
            out_data.last_point !== want.last_point ||
            out_data.unique_count !== want.unique_count ||
            out_data.overflowed !== want.overflowed) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("ERROR: result mismatch");
            $display("  expected x=%h y=%h z=%h c=%h pv=%b last=%b cnt=%0d ovf=%b",
                     want.out_x, want.out_y, want.out_z, want.color_out,
                     want.point_valid, want.last_point, want.unique_count,
                     want.overflowed);
            $display("  actual   x=%h y=%h z=%h c=%h pv=%b last=%b cnt=%0d ovf=%b",
                     out_data.out_x, out_data.out_y, out_data.out_z,
                     out_data.color_out, out_data.point_valid, out_data.last_point,
                     out_data.unique_count, out_data.overflowed);
          end
        end
      end
    end
  end

  // A generous cycle limit guards against a hung handshake.
  int cycles = 0;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic add_point(int x, int y, int z, int c, bit bad);
    in_t r;
    r.mode = MODE_LOAD;
    r.coord_x = x; r.coord_y = y; r.coord_z = z;
    r.color_in = c[23:0];
    r.invalid_in = bad;
    request_q.push_back(r);
  endtask

  // Non-load requests still carry random payload bits, which must be ignored.
  task automatic add_command(logic [1:0] m);
    in_t          r;
    logic [127:0] noise;
    noise = {$urandom, $urandom, $urandom, $urandom};
    r = noise[$bits(in_t)-1:0];
    r.mode = m;
    request_q.push_back(r);
  endtask

  // Waits until the block has nothing left to deliver or to finish.
  task automatic wait_idle();
    while (request_q.size() != 0 || in_valid || result_q.size() != 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_register(logic idx, logic [30:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_GRID_STEP) step_reg = value;
    else color_on = value[0];
  endtask

  // Coordinates near a few grid lines, so that snapping creates repeats.
  function automatic int near_grid();
    int base;
    base = $urandom_range(0, 4) * int'(step_reg > 31'd65536 ? 31'd65536 : step_reg);
    if ($urandom_range(0, 1)) base = -base;
    return base + $urandom_range(0, 64) - 32;
  endfunction

  function automatic int any_coord();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
      default: return near_grid();
    endcase
  endfunction

  // One random cloud: loads (some invalid), finish, reads, odd extras.
  task automatic random_cloud();
    int n;
    n = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 8);
    for (int i = 0; i < n; i++) begin
      add_point(any_coord(), any_coord(), any_coord(), $urandom,
                $urandom_range(0, 9) == 0);
      if ($urandom_range(0, 40) == 0) add_command(MODE_READ);
    end
    if ($urandom_range(0, 15) == 0) begin
      add_command(MODE_CLEAR);
      add_point(any_coord(), any_coord(), any_coord(), $urandom, 1'b0);
    end
    add_command(MODE_FINISH);
    for (int i = 0; i < n + 2; i++) begin
      add_command(MODE_READ);
      if ($urandom_range(0, 12) == 0) add_point($urandom, $urandom, $urandom, $urandom, 1'b0);
      if ($urandom_range(0, 30) == 0) add_command(MODE_FINISH);
    end
    add_command(MODE_CLEAR);
  endtask

  initial begin
    logic [30:0] steps[6];
    n_loaded = 0; n_kept = 0; rd_ptr = 0; ovf = 0; emitting = 0;
    step_reg = 31'd65536;
    color_on = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed: extremes, ties both ways, an invalid point, a read while
    // still loading, reads past the end, a load while emitting, a repeated
    // finish, and a clear.
    write_register(CFG_CARRY_COLOR, 31'd1);
    add_command(MODE_READ);
    add_point(32'sh80000000, 32'sh7fffffff, 0, 24'hffffff, 1'b0);
    add_point(32768, -32768, 98304, 24'h123456, 1'b0);
    add_point(32767, -32767, -98304, 24'h000000, 1'b0);
    add_point(32768, -32768, 98304, 24'hababab, 1'b0);
    add_point(5, 5, 5, 24'h0f0f0f, 1'b1);
    add_point(-65536, 0, 65536, 24'h800001, 1'b0);
    add_command(MODE_FINISH);
    add_command(MODE_READ);
    add_command(MODE_READ);
    add_point(1000000, 1, 1, 24'h111111, 1'b0);
    add_command(MODE_FINISH);
    for (int i = 0; i < 6; i++) add_command(MODE_READ);
    add_command(MODE_CLEAR);
    add_command(MODE_READ);
    add_command(MODE_FINISH);
    add_command(MODE_READ);
    add_command(MODE_CLEAR);
    wait_idle();

    // Random clouds under several register settings, extremes included.
    steps = '{31'd65536, 31'd1, 31'h7fffffff, 31'd32768, 31'd3, 31'd0};
    for (int phase = 0; phase < 8; phase++) begin
      write_register(CFG_GRID_STEP,
                     (phase < 6) ? steps[phase] : 31'($urandom_range(1, 31'h7fffffff)));
      write_register(CFG_CARRY_COLOR, 31'(phase % 2));
      random_cloud();
      wait_idle();
    end

    // Full store: descending points so the sort stays cheap, and one load
    // past capacity. A few reads then meet a long receiver hold-off that
    // makes the block stall its input.
    write_register(CFG_GRID_STEP, 31'd1);
    write_register(CFG_CARRY_COLOR, 31'd1);
    for (int i = 0; i <= MAX_POINTS; i++)
      add_point(MAX_POINTS - i, $urandom, $urandom, $urandom, 1'b0);
    add_command(MODE_FINISH);
    wait_idle();
    hold_asked++;
    for (int i = 0; i < 12; i++) add_command(MODE_READ);
    add_command(MODE_CLEAR);
    wait_idle();

    if (mismatches == 0 && result_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
